>>> rtl/cng_pkg.sv
// Shared types and constants for the colored noise generator.
// Holds the microcode word layout, the step program and the Q1.17 coefficient table.
// No dependencies.
package cng_pkg;

    localparam int COEF_W = 18;          // Q1.17 coefficients
    localparam int W_W    = 25;          // Q1.24 input sample
    localparam int Y_W    = 26;          // clamped Q2.24 value, +-1.0 inclusive

    localparam longint ONE_Q24  = 64'sd16777216;
    localparam longint HALF_Q17 = 64'sd65536;
    localparam longint PCM_BIAS = 64'sd16777215;   // rounds a negative product toward zero

    localparam logic [1:0] MODE_BROWN = 2'd0;
    localparam logic [1:0] MODE_WHITE = 2'd1;
    localparam logic [1:0] MODE_PINK  = 2'd2;

    // register index, taken from byte address bit 2
    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_MODE   = 1'b1;

    typedef logic [4:0] pc_t;

    localparam pc_t PC_DISPATCH = 5'd0;
    localparam pc_t PC_PINK     = 5'd1;
    localparam pc_t PC_BROWN    = 5'd19;
    localparam int  PROG_LEN    = 26;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [4:0] {
        C_POLE0, C_POLE1, C_POLE2, C_POLE3, C_POLE4, C_POLE5,
        C_ZERO0, C_ZERO1, C_ZERO2, C_ZERO3, C_ZERO4, C_ZERO5,
        C_DIRECT, C_LAST, C_GAIN, C_BPOLE, C_BIN, C_SIX, C_PCM
    } coef_t;

    typedef enum logic [2:0] {
        SRC_W,
        SRC_STAGE,
        SRC_SUM,
        SRC_LEVEL,
        SRC_Y
    } src_t;

    typedef enum logic [2:0] {
        WB_NONE,
        WB_STAGE_SUM,   // stage <= sat(rnd(acc)), and add it into the sum
        WB_STAGE,       // stage <= sat(rnd(acc))
        WB_LEVEL,       // level <= sat(clamp(rnd(acc)))
        WB_Y_RND,       // y <= clamp(rnd(acc))
        WB_Y_RAW,       // y <= clamp(acc)
        WB_PCM          // acc holds y*32767, result taken by the sequencer
    } wb_t;

    typedef enum logic [1:0] {
        SUM_HOLD,
        SUM_LOAD_LAST,  // sum <= stage 6 (previous value)
        SUM_ADD_RND     // sum += rnd(acc)
    } sum_op_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_DISPATCH,
        SEQ_END
    } seq_t;

    typedef struct packed {
        acc_op_t    acc_op;
        coef_t      coef;
        src_t       src;
        logic [2:0] ridx;
        wb_t        wb;
        logic [2:0] widx;
        sum_op_t    sum_op;
        seq_t       seq;
    } ctl_t;

    localparam ctl_t CTL_NOP = '{
        acc_op: ACC_HOLD, coef: C_POLE0, src: SRC_W, ridx: 3'd0,
        wb: WB_NONE, widx: 3'd0, sum_op: SUM_HOLD, seq: SEQ_NEXT
    };

    function automatic logic signed [COEF_W-1:0] coef_rom(input coef_t c);
        logic signed [COEF_W-1:0] v;
        case (c)
            C_POLE0:  v = 18'sd130923;
            C_POLE1:  v = 18'sd130196;
            C_POLE2:  v = 18'sd127009;
            C_POLE3:  v = 18'sd113574;
            C_POLE4:  v = 18'sd72090;
            C_POLE5:  v = -18'sd99824;
            C_ZERO0:  v = 18'sd7277;
            C_ZERO1:  v = 18'sd9840;
            C_ZERO2:  v = 18'sd20166;
            C_ZERO3:  v = 18'sd40696;
            C_ZERO4:  v = 18'sd69855;
            C_ZERO5:  v = -18'sd2215;
            C_DIRECT: v = 18'sd70281;
            C_LAST:   v = 18'sd15195;
            C_GAIN:   v = 18'sd14418;
            C_BPOLE:  v = 18'sd130679;
            C_BIN:    v = 18'sd6554;
            C_SIX:    v = 18'sd6;
            C_PCM:    v = 18'sd32767;
            default:  v = '0;
        endcase
        return v;
    endfunction

    function automatic ctl_t mk(input acc_op_t a, input coef_t c, input src_t s,
                                input logic [2:0] r, input wb_t w, input logic [2:0] wi,
                                input sum_op_t so, input seq_t q);
        ctl_t u;
        u.acc_op = a;
        u.coef   = c;
        u.src    = s;
        u.ridx   = r;
        u.wb     = w;
        u.widx   = wi;
        u.sum_op = so;
        u.seq    = q;
        return u;
    endfunction

    // Step program. A stage is written back while the next product loads into the accumulator.
    function automatic ctl_t ucode(input pc_t pc);
        ctl_t u;
        u = CTL_NOP;
        case (pc)
            PC_DISPATCH: u = mk(ACC_HOLD, C_POLE0, SRC_W, 3'd0, WB_NONE, 3'd0,
                                SUM_HOLD, SEQ_DISPATCH);
            // pink
            5'd1:  u = mk(ACC_LOAD, C_POLE0, SRC_STAGE, 3'd0, WB_NONE, 3'd0,
                          SUM_LOAD_LAST, SEQ_NEXT);
            5'd2:  u = mk(ACC_ADD, C_ZERO0, SRC_W, 3'd0, WB_NONE, 3'd0, SUM_HOLD, SEQ_NEXT);
            5'd3:  u = mk(ACC_LOAD, C_POLE1, SRC_STAGE, 3'd1, WB_STAGE_SUM, 3'd0,
                          SUM_HOLD, SEQ_NEXT);
            5'd4:  u = mk(ACC_ADD, C_ZERO1, SRC_W, 3'd0, WB_NONE, 3'd0, SUM_HOLD, SEQ_NEXT);
            5'd5:  u = mk(ACC_LOAD, C_POLE2, SRC_STAGE, 3'd2, WB_STAGE_SUM, 3'd1,
                          SUM_HOLD, SEQ_NEXT);
            5'd6:  u = mk(ACC_ADD, C_ZERO2, SRC_W, 3'd0, WB_NONE, 3'd0, SUM_HOLD, SEQ_NEXT);
            5'd7:  u = mk(ACC_LOAD, C_POLE3, SRC_STAGE, 3'd3, WB_STAGE_SUM, 3'd2,
                          SUM_HOLD, SEQ_NEXT);
            5'd8:  u = mk(ACC_ADD, C_ZERO3, SRC_W, 3'd0, WB_NONE, 3'd0, SUM_HOLD, SEQ_NEXT);
            5'd9:  u = mk(ACC_LOAD, C_POLE4, SRC_STAGE, 3'd4, WB_STAGE_SUM, 3'd3,
                          SUM_HOLD, SEQ_NEXT);
            5'd10: u = mk(ACC_ADD, C_ZERO4, SRC_W, 3'd0, WB_NONE, 3'd0, SUM_HOLD, SEQ_NEXT);
            5'd11: u = mk(ACC_LOAD, C_POLE5, SRC_STAGE, 3'd5, WB_STAGE_SUM, 3'd4,
                          SUM_HOLD, SEQ_NEXT);
            5'd12: u = mk(ACC_ADD, C_ZERO5, SRC_W, 3'd0, WB_NONE, 3'd0, SUM_HOLD, SEQ_NEXT);
            5'd13: u = mk(ACC_LOAD, C_DIRECT, SRC_W, 3'd0, WB_STAGE_SUM, 3'd5,
                          SUM_HOLD, SEQ_NEXT);
            5'd14: u = mk(ACC_LOAD, C_LAST, SRC_W, 3'd0, WB_NONE, 3'd0,
                          SUM_ADD_RND, SEQ_NEXT);
            5'd15: u = mk(ACC_LOAD, C_GAIN, SRC_SUM, 3'd0, WB_STAGE, 3'd6,
                          SUM_HOLD, SEQ_NEXT);
            5'd16: u = mk(ACC_HOLD, C_POLE0, SRC_W, 3'd0, WB_Y_RND, 3'd0, SUM_HOLD, SEQ_NEXT);
            5'd17: u = mk(ACC_LOAD, C_PCM, SRC_Y, 3'd0, WB_NONE, 3'd0, SUM_HOLD, SEQ_NEXT);
            5'd18: u = mk(ACC_HOLD, C_POLE0, SRC_W, 3'd0, WB_PCM, 3'd0, SUM_HOLD, SEQ_END);
            // brown
            5'd19: u = mk(ACC_LOAD, C_BPOLE, SRC_LEVEL, 3'd0, WB_NONE, 3'd0,
                          SUM_HOLD, SEQ_NEXT);
            5'd20: u = mk(ACC_ADD, C_BIN, SRC_W, 3'd0, WB_NONE, 3'd0, SUM_HOLD, SEQ_NEXT);
            5'd21: u = mk(ACC_HOLD, C_POLE0, SRC_W, 3'd0, WB_LEVEL, 3'd0, SUM_HOLD, SEQ_NEXT);
            5'd22: u = mk(ACC_LOAD, C_SIX, SRC_LEVEL, 3'd0, WB_NONE, 3'd0, SUM_HOLD, SEQ_NEXT);
            5'd23: u = mk(ACC_HOLD, C_POLE0, SRC_W, 3'd0, WB_Y_RAW, 3'd0, SUM_HOLD, SEQ_NEXT);
            5'd24: u = mk(ACC_LOAD, C_PCM, SRC_Y, 3'd0, WB_NONE, 3'd0, SUM_HOLD, SEQ_NEXT);
            5'd25: u = mk(ACC_HOLD, C_POLE0, SRC_W, 3'd0, WB_PCM, 3'd0, SUM_HOLD, SEQ_END);
            default: u = mk(ACC_HOLD, C_POLE0, SRC_W, 3'd0, WB_NONE, 3'd0, SUM_HOLD, SEQ_END);
        endcase
        return u;
    endfunction

endpackage

>>> rtl/colored_noise_generator.sv
// Colored noise generator: white, pink (eight-term filter bank) or brown noise frames.
// An item is taken only when the sequencer is idle, so each word runs through the step
// program on the single multiplier before the next is taken; a blocked output holds it busy.
// Reset (rst_n low, async) zeroes filter state, enables output and selects pink mode.
// Depends on cng_pkg and cng_datapath.
module colored_noise_generator #(
    parameter int STATE_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        random_word,
    input  logic               block_end,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] left_sample,
    output logic signed [15:0] right_sample,
    output logic               block_end_out
);

    logic               en_reg, en_next;
    logic [1:0]         mode_reg, mode_next;
    logic               busy_reg, busy_next;
    cng_pkg::pc_t       pc_reg, pc_next;
    logic [15:0]        white_reg, white_next;
    logic               blk_reg, blk_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] sample_reg, sample_next;
    logic               blk_out_reg, blk_out_next;

    cng_pkg::ctl_t      ucw;
    cng_pkg::ctl_t      dp_ctl;
    logic               accept;
    logic               cfg_wr;
    logic               out_free;
    logic               quick;
    logic               fin;
    logic               stall;
    logic signed [15:0] pcm;

    assign pready        = 1'b1;
    assign in_ready      = !busy_reg;
    assign accept        = in_valid && !busy_reg;
    assign cfg_wr        = psel && penable && pwrite;
    assign out_valid     = out_valid_reg;
    assign left_sample   = sample_reg;
    assign right_sample  = sample_reg;
    assign block_end_out = blk_out_reg;

    always_comb
    begin
        unique case (paddr[2])
            cng_pkg::REG_ENABLE: prdata = {31'b0, en_reg};
            cng_pkg::REG_MODE:   prdata = {30'b0, mode_reg};
        endcase
    end

    always_comb
    begin
        en_next   = en_reg;
        mode_next = mode_reg;
        if (cfg_wr)
        begin
            if (paddr[2] == cng_pkg::REG_ENABLE)
                en_next = pwdata[0];
            else
                mode_next = pwdata[1:0];
        end
    end

    // sequencer
    always_comb
    begin
        ucw      = cng_pkg::ucode(pc_reg);
        out_free = !out_valid_reg || out_ready;
        quick    = !en_reg || (mode_reg == cng_pkg::MODE_WHITE);
        fin      = busy_reg && (((ucw.seq == cng_pkg::SEQ_DISPATCH) && quick) ||
                                (ucw.seq == cng_pkg::SEQ_END));
        stall    = fin && !out_free;
        dp_ctl   = (busy_reg && !stall) ? ucw : cng_pkg::CTL_NOP;

        busy_next  = busy_reg;
        pc_next    = pc_reg;
        white_next = white_reg;
        blk_next   = blk_reg;
        if (accept)
        begin
            busy_next  = 1'b1;
            pc_next    = cng_pkg::PC_DISPATCH;
            white_next = random_word[15:0];
            blk_next   = block_end;
        end
        else if (busy_reg && !stall)
        begin
            unique case (ucw.seq)
                cng_pkg::SEQ_NEXT:
                begin
                    pc_next = pc_reg + 5'd1;
                end
                cng_pkg::SEQ_DISPATCH:
                begin
                    if (quick)
                        busy_next = 1'b0;
                    else if (mode_reg == cng_pkg::MODE_PINK)
                        pc_next = cng_pkg::PC_PINK;
                    else
                        pc_next = cng_pkg::PC_BROWN;   // brown and the spare code
                end
                cng_pkg::SEQ_END:
                begin
                    busy_next = 1'b0;
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end

        out_valid_next = out_valid_reg;
        sample_next    = sample_reg;
        blk_out_next   = blk_out_reg;
        if (fin && !stall)
        begin
            out_valid_next = 1'b1;
            blk_out_next   = blk_reg;
            if (ucw.seq == cng_pkg::SEQ_END)
                sample_next = pcm;
            else if (!en_reg)
                sample_next = '0;
            else
                sample_next = {~white_reg[15], white_reg[14:0]};   // low half minus 0x8000
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg        <= 1'b1;
            mode_reg      <= cng_pkg::MODE_PINK;
            busy_reg      <= 1'b0;
            pc_reg        <= cng_pkg::PC_DISPATCH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            en_reg        <= en_next;
            mode_reg      <= mode_next;
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        white_reg   <= white_next;
        blk_reg     <= blk_next;
        sample_reg  <= sample_next;
        blk_out_reg <= blk_out_next;
    end

    cng_datapath #(
        .STATE_WIDTH (STATE_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .random_word (random_word),
        .ctl         (dp_ctl),
        .pcm         (pcm)
    );

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> busy_reg && pc_reg == cng_pkg::PC_DISPATCH)
        else $error("accepted word did not start at dispatch");

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> int'(pc_reg) < cng_pkg::PROG_LEN)
        else $error("step counter outside program");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> busy_reg && $stable(pc_reg))
        else $error("sequencer moved while output was blocked");

    a_muted_zero: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && pc_reg == cng_pkg::PC_DISPATCH && !en_reg && out_free
        |=> out_valid_reg && sample_reg == 16'sd0 && !busy_reg)
        else $error("muted word did not give a silent frame");

endmodule

>>> rtl/cng_datapath.sv
// Filter datapath: one coefficient multiplier, accumulator, Q8.24 filter state.
// Driven one control word per cycle by the sequencer in colored_noise_generator.
// Depends on cng_pkg.
module cng_datapath #(
    parameter int STATE_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic [31:0]           random_word,
    input  cng_pkg::ctl_t         ctl,
    output logic signed [15:0]    pcm
);

    localparam int SW     = STATE_WIDTH;
    localparam int OPD_W  = SW + 4;
    localparam int SUM_W  = SW + 4;
    localparam int PROD_W = cng_pkg::COEF_W + OPD_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int RND_W  = ACC_W - 17;
    localparam int Y_W    = cng_pkg::Y_W;

    localparam logic signed [ACC_W-1:0] A_HALF = ACC_W'(cng_pkg::HALF_Q17);
    localparam logic signed [ACC_W-1:0] A_BIAS = ACC_W'(cng_pkg::PCM_BIAS);
    localparam logic signed [ACC_W-1:0] A_ONE  = ACC_W'(cng_pkg::ONE_Q24);
    localparam logic signed [ACC_W-1:0] A_MONE = ACC_W'(-cng_pkg::ONE_Q24);
    localparam logic signed [RND_W-1:0] R_ONE  = RND_W'(cng_pkg::ONE_Q24);
    localparam logic signed [RND_W-1:0] R_MONE = RND_W'(-cng_pkg::ONE_Q24);
    localparam logic signed [RND_W-1:0] S_MAX  =
        RND_W'((64'sd1 <<< (STATE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [RND_W-1:0] S_MIN  = RND_W'(-(64'sd1 <<< (STATE_WIDTH - 1)));

    logic signed [cng_pkg::W_W-1:0] w_reg, w_next;
    logic signed [ACC_W-1:0]        acc_reg, acc_next;
    logic signed [SUM_W-1:0]        sum_reg, sum_next;
    logic signed [Y_W-1:0]          y_reg, y_next;
    logic signed [SW-1:0]           level_reg, level_next;
    logic signed [SW-1:0]           stage_reg [7];
    logic signed [SW-1:0]           stage_next [7];

    logic signed [cng_pkg::COEF_W-1:0] coef_v;
    logic signed [OPD_W-1:0]           opnd;
    logic signed [PROD_W-1:0]          prod;
    logic signed [ACC_W-1:0]           acc_half;
    logic signed [ACC_W-1:0]           acc_clamp;
    logic signed [ACC_W-1:0]           pcm_adj;
    logic signed [RND_W-1:0]           rnd;
    logic signed [RND_W-1:0]           rnd_sat;
    logic signed [RND_W-1:0]           rnd_clamp;
    logic signed [RND_W-1:0]           lvl_sat;
    logic signed [SW-1:0]              stage_val;
    logic                              stage_wr;

    always_comb
    begin
        coef_v = cng_pkg::coef_rom(ctl.coef);
        case (ctl.src)
            cng_pkg::SRC_W:     opnd = OPD_W'(w_reg);
            cng_pkg::SRC_STAGE: opnd = OPD_W'(stage_reg[ctl.ridx]);
            cng_pkg::SRC_SUM:   opnd = sum_reg;
            cng_pkg::SRC_LEVEL: opnd = OPD_W'(level_reg);
            cng_pkg::SRC_Y:     opnd = OPD_W'(y_reg);
            default:            opnd = '0;
        endcase
        prod = coef_v * opnd;

        // round half up at bit 17, floor shift
        acc_half = acc_reg + A_HALF;
        rnd      = acc_half[ACC_W-1:17];

        if (rnd > S_MAX)
            rnd_sat = S_MAX;
        else if (rnd < S_MIN)
            rnd_sat = S_MIN;
        else
            rnd_sat = rnd;

        if (rnd > R_ONE)
            rnd_clamp = R_ONE;
        else if (rnd < R_MONE)
            rnd_clamp = R_MONE;
        else
            rnd_clamp = rnd;

        if (rnd_clamp > S_MAX)
            lvl_sat = S_MAX;
        else if (rnd_clamp < S_MIN)
            lvl_sat = S_MIN;
        else
            lvl_sat = rnd_clamp;

        if (acc_reg > A_ONE)
            acc_clamp = A_ONE;
        else if (acc_reg < A_MONE)
            acc_clamp = A_MONE;
        else
            acc_clamp = acc_reg;

        // truncate toward zero: bias negatives before the shift
        pcm_adj = acc_reg + (acc_reg[ACC_W-1] ? A_BIAS : '0);
        pcm     = pcm_adj[24 +: 16];
    end

    always_comb
    begin
        w_next = load ? $signed(random_word[31:7]) : w_reg;

        case (ctl.acc_op)
            cng_pkg::ACC_LOAD: acc_next = ACC_W'(prod);
            cng_pkg::ACC_ADD:  acc_next = acc_reg + ACC_W'(prod);
            default:           acc_next = acc_reg;
        endcase

        stage_val = rnd_sat[SW-1:0];
        stage_wr  = (ctl.wb == cng_pkg::WB_STAGE_SUM) || (ctl.wb == cng_pkg::WB_STAGE);
        for (int i = 0; i < 7; i++)
        begin
            stage_next[i] = (stage_wr && ctl.widx == 3'(i)) ? stage_val : stage_reg[i];
        end

        case (ctl.sum_op)
            cng_pkg::SUM_LOAD_LAST: sum_next = SUM_W'(stage_reg[6]);
            cng_pkg::SUM_ADD_RND:   sum_next = sum_reg + SUM_W'(rnd);
            default:                sum_next = sum_reg;
        endcase
        if (ctl.wb == cng_pkg::WB_STAGE_SUM)
            sum_next = sum_next + SUM_W'(stage_val);

        case (ctl.wb)
            cng_pkg::WB_Y_RND: y_next = rnd_clamp[Y_W-1:0];
            cng_pkg::WB_Y_RAW: y_next = acc_clamp[Y_W-1:0];
            default:           y_next = y_reg;
        endcase

        level_next = (ctl.wb == cng_pkg::WB_LEVEL) ? lvl_sat[SW-1:0] : level_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            for (int i = 0; i < 7; i++)
            begin
                stage_reg[i] <= '0;
            end
        end
        else
        begin
            level_reg <= level_next;
            for (int i = 0; i < 7; i++)
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg   <= w_next;
        acc_reg <= acc_next;
        sum_reg <= sum_next;
        y_reg   <= y_next;
    end

endmodule
